// File: hw/rtl/mmh64_pkg.sv
`default_nettype none

package mmh64_pkg;

  localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
  localparam int unsigned MIX_SHIFT = 47;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned HALF_W = WORD_W / 2;

  // request to the shared multiplier: operand times MIX_MUL, mod 2^64
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] operand;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_rsp_t;

  function automatic logic [WORD_W-1:0] xor_shift(input logic [WORD_W-1:0] x);
    return x ^ (x >> MIX_SHIFT);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mmh64_mul.sv
`default_nettype none

module mmh64_mul (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire mmh64_pkg::mul_req_t       req_i,
  output mmh64_pkg::mul_rsp_t            rsp_o,
  output logic [mmh64_pkg::WORD_W-1:0]   prod_o
);
  import mmh64_pkg::*;

  typedef enum logic [2:0] {
    STEP_LL = 3'b001,
    STEP_HL = 3'b010,
    STEP_LH = 3'b100
  } step_e;

  localparam logic [HALF_W-1:0] MUL_LO = MIX_MUL[HALF_W-1:0];
  localparam logic [HALF_W-1:0] MUL_HI = MIX_MUL[WORD_W-1:HALF_W];

  step_e             step_q;
  logic              busy_q;
  logic              done_q;
  logic [WORD_W-1:0] a_q;
  logic [WORD_W-1:0] acc_q;

  logic [HALF_W-1:0] mul_a;
  logic [HALF_W-1:0] mul_b;
  logic [WORD_W-1:0] prod;
  logic [HALF_W-1:0] hi_sum;

  // one 32x32 multiplier; cross terms only need their low half
  always_comb begin
    mul_a = req_i.operand[HALF_W-1:0];
    mul_b = MUL_LO;
    if (busy_q) begin
      case (step_q)
        STEP_HL: begin
          mul_a = a_q[WORD_W-1:HALF_W];
          mul_b = MUL_LO;
        end
        STEP_LH: begin
          mul_a = a_q[HALF_W-1:0];
          mul_b = MUL_HI;
        end
        default: begin
          mul_a = a_q[HALF_W-1:0];
          mul_b = MUL_LO;
        end
      endcase
    end
  end

  assign prod   = WORD_W'(mul_a) * WORD_W'(mul_b);
  assign hi_sum = acc_q[WORD_W-1:HALF_W] + prod[HALF_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_LL;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      // done pulses for one cycle after the last cross term
      done_q <= !req_i.start && busy_q && (step_q == STEP_LH);
      if (req_i.start) begin
        step_q <= STEP_HL;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        case (step_q)
          STEP_HL: step_q <= STEP_LH;
          STEP_LH: begin
            step_q <= STEP_LL;
            busy_q <= 1'b0;
          end
          default: begin
            step_q <= STEP_LL;
            busy_q <= 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.operand;
      acc_q <= prod;
    end else if (busy_q && (step_q == STEP_HL || step_q == STEP_LH)) begin
      acc_q[WORD_W-1:HALF_W] <= hi_sum;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign prod_o     = acc_q;

  a_no_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("multiplier restarted while busy");

  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(busy_q) && $past(step_q) == STEP_LH))
    else $error("multiplier done without finishing last step");

endmodule

`default_nettype wire

// File: hw/rtl/murmur2_64bit_hash_top.sv
// MurmurHash64A engine, one 64-bit message word per item, one shared 32x32 multiplier.
// Per item: a full word needs two k multiplies and one h multiply, a partial word one h
//   multiply, a zero-byte word none; the first word adds the length multiply, the last the
//   avalanche multiply and the output register. One item is in flight at a time (in_stall_o),
//   each 64-bit multiply in three steps on one unit; a last item also waits while a held result is stalled.
// Reset (async, rst_ni low): seed 0, running hash 0, next item opens a message, output empty.
`default_nettype none

module murmur2_64bit_hash_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config: seed register
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [63:0] cfg_data_i,
  // input items
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] data_word_i,
  input  wire logic [3:0]  valid_bytes_i,
  input  wire logic [30:0] message_length_i,
  input  wire logic        last_word_i,
  // result items
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      hash_value_o
);
  import mmh64_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,  // waiting for an item
    S_INIT = 9'b000000010,  // length * M in flight
    S_DISP = 9'b000000100,  // pick word path
    S_K1   = 9'b000001000,  // k * M in flight
    S_K2   = 9'b000010000,  // second k * M in flight
    S_HM   = 9'b000100000,  // h * M in flight
    S_FIN  = 9'b001000000,  // end of item
    S_AV   = 9'b010000000,  // avalanche multiply in flight
    S_OUT  = 9'b100000000   // move result to output register
  } state_e;

  state_e            state_q;
  logic              start_q;      // next item opens a message
  logic [WORD_W-1:0] seed_q;
  logic [WORD_W-1:0] h_q;          // running hash
  logic [WORD_W-1:0] word_q;
  logic              full_q;
  logic [2:0]        cnt_q;
  logic              last_q;
  logic              out_valid_q;
  logic [WORD_W-1:0] hash_q;

  mul_req_t          mul_req;
  mul_rsp_t          mul_rsp;
  logic [WORD_W-1:0] prod;

  logic              in_acc;
  logic              out_free;
  logic [WORD_W-1:0] tail_mask;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;

  // low bytes below the count survive
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      tail_mask[i*8 +: 8] = (3'(i) < cnt_q) ? 8'hff : 8'h00;
    end
  end

  // multiplier issue: in K1 and K2 in the cycle the previous product lands, else from IDLE, DISP and FIN
  always_comb begin
    mul_req.start   = 1'b0;
    mul_req.operand = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc && start_q) begin
          mul_req.start   = 1'b1;
          mul_req.operand = {{(WORD_W-31){1'b0}}, message_length_i};
        end
      end
      S_DISP: begin
        if (full_q) begin
          mul_req.start   = 1'b1;
          mul_req.operand = word_q;
        end else if (cnt_q != 3'd0) begin
          mul_req.start   = 1'b1;
          mul_req.operand = h_q ^ (word_q & tail_mask);
        end
      end
      S_K1: begin
        if (mul_rsp.done) begin
          mul_req.start   = 1'b1;
          mul_req.operand = xor_shift(prod);
        end
      end
      S_K2: begin
        if (mul_rsp.done) begin
          mul_req.start   = 1'b1;
          mul_req.operand = h_q ^ prod;
        end
      end
      S_FIN: begin
        if (last_q) begin
          mul_req.start   = 1'b1;
          mul_req.operand = xor_shift(h_q);
        end
      end
      default: begin
        mul_req.start   = 1'b0;
        mul_req.operand = '0;
      end
    endcase
  end

  mmh64_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp),
    .prod_o (prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b1;
      seed_q      <= '0;
      h_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        seed_q <= cfg_data_i;
      end
      // a new result may replace one leaving in the same cycle
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= start_q ? S_INIT : S_DISP;
          end
        end
        S_INIT: begin
          if (mul_rsp.done) begin
            h_q     <= seed_q ^ prod;
            state_q <= S_DISP;
          end
        end
        S_DISP: begin
          if (full_q) begin
            state_q <= S_K1;
          end else if (cnt_q != 3'd0) begin
            state_q <= S_HM;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_K1: begin
          if (mul_rsp.done) begin
            state_q <= S_K2;
          end
        end
        S_K2: begin
          if (mul_rsp.done) begin
            state_q <= S_HM;
          end
        end
        S_HM: begin
          if (mul_rsp.done) begin
            h_q     <= prod;
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          start_q <= last_q;
          state_q <= last_q ? S_AV : S_IDLE;
        end
        S_AV: begin
          if (mul_rsp.done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          // product register holds until the next issue
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      word_q <= data_word_i;
      full_q <= valid_bytes_i[3];     // eight or more: full word
      cnt_q  <= valid_bytes_i[2:0];
      last_q <= last_word_i;
    end
    if (state_q == S_OUT && out_free) begin
      hash_q <= xor_shift(prod);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

  a_done_when_waiting : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> (state_q == S_INIT || state_q == S_K1 || state_q == S_K2 ||
                      state_q == S_HM || state_q == S_AV))
    else $error("multiplier result arrived with nobody waiting");

  a_out_mul_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT || state_q == S_IDLE) |-> !mul_rsp.busy)
    else $error("multiplier busy outside a wait state");

  a_result_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("result not loaded into output register");

endmodule

`default_nettype wire
